// File: rtl/core/pwm_tone_sequencer_macros.svh
// Assertion macros used by the checker file of the tone sequencer.
// Included by bare file name; no other dependencies.
`ifndef PWM_TONE_SEQUENCER_MACROS_SVH
`define PWM_TONE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PWMTS_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwm_tone_sequencer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define PWMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwm_tone_sequencer: next-cycle check failed");

`endif

// File: rtl/core/pwmts_pkg.sv
// Package of the PWM tone sequencer: command and register codes, tone entry
// layouts and arithmetic constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwmts_pkg;

  // Input commands
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd1;

  localparam logic [9:0] VOLUME_RESET = 10'd1023;
  localparam logic       INVERT_RESET = 1'b1;

  // Period arithmetic: 1e6 us divided by the mean frequency, capped
  localparam int              QUO_W      = 20;
  localparam logic [QUO_W-1:0] DIVIDEND  = 20'd1000000;
  localparam logic [15:0]     PERIOD_CAP = 16'hfff0;
  localparam int              LEVEL_SHIFT = 11;

  // Tone entry layouts as stored in the tone memory
  typedef struct packed {
    logic [15:0] end_freq;
    logic [15:0] start_freq;
  } tone_pitch_t;

  typedef struct packed {
    logic [15:0] duration;
    logic [9:0]  end_level;
    logic [9:0]  start_level;
  } tone_lt_t;

endpackage

`default_nettype wire

// File: rtl/core/pwmts_if.sv
// Channel interfaces of the PWM tone sequencer: input items, results and
// configuration writes. Uses pwmts_pkg for the configuration widths.
`timescale 1ns / 1ps
`default_nettype none

interface pwmts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  tone_index;
  logic [15:0] start_frequency;
  logic [15:0] end_frequency;
  logic [9:0]  start_level;
  logic [9:0]  end_level;
  logic [15:0] duration_ms;
  logic [4:0]  tone_count;

  modport source (output valid, command, tone_index, start_frequency, end_frequency,
                  start_level, end_level, duration_ms, tone_count, input ready);
  modport sink   (input valid, command, tone_index, start_frequency, end_frequency,
                  start_level, end_level, duration_ms, tone_count, output ready);
endinterface

interface pwmts_out_if;
  logic        valid;
  logic        ready;
  logic        drive_on;
  logic [15:0] period_us;
  logic [15:0] duty_us;
  logic        tone_changed;
  logic [3:0]  playing_index;

  modport source (output valid, drive_on, period_us, duty_us, tone_changed, playing_index,
                  input ready);
  modport sink   (input valid, drive_on, period_us, duty_us, tone_changed, playing_index,
                  output ready);
endinterface

interface pwmts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pwmts_pkg::CFG_IDX_W-1:0]  index;
  logic [pwmts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pwmts_tone_mem.sv
// Tone table of the PWM tone sequencer: pitch and level/duration memories,
// one write port and one registered read port. Uses pwmts_pkg entry types.
`timescale 1ns / 1ps
`default_nettype none

module pwmts_tone_mem #(
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [ADDR_W-1:0]             wr_addr,
  input  wire pwmts_pkg::tone_pitch_t  wr_pitch,
  input  wire pwmts_pkg::tone_lt_t     wr_lt,
  input  wire                          rd_en,
  input  wire [ADDR_W-1:0]             rd_addr,
  output pwmts_pkg::tone_pitch_t       rd_pitch,
  output pwmts_pkg::tone_lt_t          rd_lt
);

  pwmts_pkg::tone_pitch_t pitch_mem [DEPTH];
  pwmts_pkg::tone_lt_t    lt_mem    [DEPTH];
  pwmts_pkg::tone_pitch_t rd_pitch_r;
  pwmts_pkg::tone_lt_t    rd_lt_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pitch_mem[wr_addr] <= wr_pitch;
      lt_mem[wr_addr]    <= wr_lt;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pitch_r <= pitch_mem[rd_addr];
      rd_lt_r    <= lt_mem[rd_addr];
    end
  end

  assign rd_pitch = rd_pitch_r;
  assign rd_lt    = rd_lt_r;

endmodule

`default_nettype wire

// File: rtl/core/pwmts_div.sv
// Serial radix-2 restoring divider: constant dividend (1e6) by a 16-bit
// divisor, one quotient bit per cycle. Uses pwmts_pkg constants.
`timescale 1ns / 1ps
`default_nettype none

module pwmts_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire  [15:0]                 divisor,
  output logic                        done,
  output logic [pwmts_pkg::QUO_W-1:0] quotient
);

  localparam int QW    = pwmts_pkg::QUO_W;
  localparam int CNT_W = $clog2(QW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [QW-1:0]     quo_r, quo_nxt;
  logic [15:0]       dvs_r, dvs_nxt;
  logic [16:0]       shifted;
  logic              ge;

  // One restoring step: shift in the next dividend bit, try to subtract
  always_comb begin
    shifted  = {rem_r, quo_r[QW-1]};
    ge       = shifted >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QW - 1);
      rem_nxt  = '0;
      quo_nxt  = pwmts_pkg::DIVIDEND;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 16'(shifted - {1'b0, dvs_r}) : shifted[15:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/core/pwm_tone_sequencer.sv
// PWM tone sequencer top level: tone table memory, period divider and the
// sequencing control. Uses pwmts_pkg, pwmts_if, pwmts_tone_mem, pwmts_div.
//
// Usage:
//   in_ch  : valid/ready item channel. Commands write a tone entry, start
//            playback of tone_count entries, or deliver a 1 ms tick.
//   out_ch : valid/ready result channel, exactly one result per item with the
//            drive state, PWM period and duty and the sounding tone index.
//   cfg_ch : valid/ready register write (0 volume, 1 invert_duty), always
//            ready; write it only while no item is in flight.
// Sequencing: one item at a time. An item that begins a new tone passes from
//   acceptance to result through one memory read, 20 divider steps for the
//   period, one level multiply overlapped with the divider, one duty multiply,
//   one commit and the result load. Other items go straight to the result load.
// Reset (rst_n, synchronous, active low): drive off, no tones loaded, volume
//   1023, invert_duty 1. The tone table is not cleared; play only written
//   entries.
// Stall: the result sits in an output register; the next item is accepted
//   while it waits, and that item's result is held back until out_ch.ready.
`timescale 1ns / 1ps
`default_nettype none

module pwm_tone_sequencer #(
  parameter int MAX_TONES = 16
) (
  input  wire            clk,
  input  wire            rst_n,
  pwmts_in_if.sink       in_ch,
  pwmts_out_if.source    out_ch,
  pwmts_cfg_if.sink      cfg_ch
);

  localparam int ADDR_W = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int POS_W  = $clog2(MAX_TONES + 1);
  localparam int QW     = pwmts_pkg::QUO_W;
  localparam int LS     = pwmts_pkg::LEVEL_SHIFT;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FETCH  = 6'b000010,
    S_DIV    = 6'b000100,
    S_MUL    = 6'b001000,
    S_COMMIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;

  // Sequencing state
  logic [POS_W-1:0]  loaded_r, loaded_nxt;
  logic [POS_W-1:0]  next_pos_r, next_pos_nxt;
  logic [15:0]       rem_ms_r, rem_ms_nxt;
  logic              drive_r, drive_nxt;
  logic [15:0]       cur_period_r, cur_period_nxt;
  logic [15:0]       cur_duty_r, cur_duty_nxt;
  logic              changed_r, changed_nxt;

  // Configuration registers
  logic [9:0]        volume_r, volume_nxt;
  logic              invert_r, invert_nxt;

  // Per-tone working registers
  logic              mean_zero_r, mean_zero_nxt;
  logic [9:0]        lvl_r, lvl_nxt;
  logic [8:0]        lvl_scaled_r, lvl_scaled_nxt;
  logic [15:0]       dur_r, dur_nxt;
  logic [15:0]       period_r, period_nxt;
  logic [13:0]       duty_raw_r, duty_raw_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_drive_r, out_drive_nxt;
  logic [15:0]       out_period_r, out_period_nxt;
  logic [15:0]       out_duty_r, out_duty_nxt;
  logic              out_changed_r, out_changed_nxt;
  logic [3:0]        out_index_r, out_index_nxt;

  // Memory and divider hookup
  logic                   mem_wr_en;
  logic [ADDR_W-1:0]      mem_wr_addr;
  pwmts_pkg::tone_pitch_t mem_wr_pitch;
  pwmts_pkg::tone_lt_t    mem_wr_lt;
  logic                   mem_rd_en;
  logic [ADDR_W-1:0]      mem_rd_addr;
  pwmts_pkg::tone_pitch_t mem_rd_pitch;
  pwmts_pkg::tone_lt_t    mem_rd_lt;
  logic                   div_start;
  logic                   div_done;
  logic [QW-1:0]          div_quo;

  // Decode helpers
  logic                   in_fire;
  logic                   idx_ok;
  logic [POS_W-1:0]       count_sat;
  logic [15:0]            rem_dec;
  logic [16:0]            freq_sum;
  logic [10:0]            lvl_sum;
  logic [19:0]            vol_prod;
  logic [24:0]            duty_prod;

  pwmts_tone_mem #(
    .DEPTH (MAX_TONES)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_pitch (mem_wr_pitch),
    .wr_lt    (mem_wr_lt),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_pitch (mem_rd_pitch),
    .rd_lt    (mem_rd_lt)
  );

  pwmts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (freq_sum[16:1]),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && (state_r == S_IDLE);

  // Table write on a write transaction inside the table
  assign idx_ok        = 32'(in_ch.tone_index) < 32'(MAX_TONES);
  assign mem_wr_en     = in_fire && (in_ch.command == pwmts_pkg::CMD_WRITE) && idx_ok;
  assign mem_wr_addr   = ADDR_W'(in_ch.tone_index);
  assign mem_wr_pitch  = '{end_freq: in_ch.end_frequency, start_freq: in_ch.start_frequency};
  assign mem_wr_lt     = '{duration: in_ch.duration_ms, end_level: in_ch.end_level,
                           start_level: in_ch.start_level};

  assign count_sat = (32'(in_ch.tone_count) > 32'(MAX_TONES)) ? POS_W'(MAX_TONES)
                                                              : POS_W'(in_ch.tone_count);
  assign rem_dec   = (rem_ms_r != 16'd0) ? rem_ms_r - 16'd1 : 16'd0;

  // Mean frequency and mean level of the fetched entry; the mean of two
  // 10-bit levels never exceeds 1023, so its cap is implicit
  assign freq_sum  = 17'(mem_rd_pitch.start_freq) + 17'(mem_rd_pitch.end_freq);
  assign lvl_sum   = 11'(mem_rd_lt.start_level) + 11'(mem_rd_lt.end_level);
  assign vol_prod  = 20'(lvl_r) * 20'(volume_r);
  assign duty_prod = 25'(period_r) * 25'(lvl_scaled_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    loaded_nxt     = loaded_r;
    next_pos_nxt   = next_pos_r;
    rem_ms_nxt     = rem_ms_r;
    drive_nxt      = drive_r;
    cur_period_nxt = cur_period_r;
    cur_duty_nxt   = cur_duty_r;
    changed_nxt    = changed_r;
    mean_zero_nxt  = mean_zero_r;
    lvl_nxt        = lvl_r;
    lvl_scaled_nxt = lvl_scaled_r;
    dur_nxt        = dur_r;
    period_nxt     = period_r;
    duty_raw_nxt   = duty_raw_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = ADDR_W'(next_pos_r);
    div_start      = 1'b0;

    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_drive_nxt   = out_drive_r;
    out_period_nxt  = out_period_r;
    out_duty_nxt    = out_duty_r;
    out_changed_nxt = out_changed_r;
    out_index_nxt   = out_index_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          changed_nxt = 1'b0;
          state_nxt   = S_DONE;
          unique case (in_ch.command)
            pwmts_pkg::CMD_START: begin
              loaded_nxt   = count_sat;
              next_pos_nxt = '0;
              rem_ms_nxt   = 16'd0;
              if (count_sat == '0) begin
                drive_nxt = 1'b0;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                state_nxt   = S_FETCH;
              end
            end
            pwmts_pkg::CMD_TICK: begin
              if (loaded_r == '0) begin
                drive_nxt = 1'b0;
              end else begin
                rem_ms_nxt = rem_dec;
                if (rem_dec == 16'd0) begin
                  if (next_pos_r >= loaded_r) begin
                    drive_nxt = 1'b0;
                  end else begin
                    mem_rd_en = 1'b1;
                    state_nxt = S_FETCH;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        div_start     = 1'b1;
        mean_zero_nxt = (freq_sum[16:1] == 16'd0);
        lvl_nxt       = lvl_sum[10:1];
        dur_nxt       = mem_rd_lt.duration;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        // level scaling runs alongside the divider
        lvl_scaled_nxt = vol_prod[19:LS];
        if (div_done) begin
          if (mean_zero_r || (div_quo > QW'(pwmts_pkg::PERIOD_CAP))) begin
            period_nxt = pwmts_pkg::PERIOD_CAP;
          end else begin
            period_nxt = div_quo[15:0];
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        duty_raw_nxt = duty_prod[24:LS];
        state_nxt    = S_COMMIT;
      end
      S_COMMIT: begin
        cur_period_nxt = period_r;
        cur_duty_nxt   = invert_r ? period_r - 16'(duty_raw_r) : 16'(duty_raw_r);
        rem_ms_nxt     = dur_r;
        drive_nxt      = 1'b1;
        next_pos_nxt   = next_pos_r + 1'b1;
        changed_nxt    = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // load the result once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_drive_nxt   = drive_r;
          out_period_nxt  = drive_r ? cur_period_r : 16'd0;
          out_duty_nxt    = drive_r ? cur_duty_r : 16'd0;
          out_changed_nxt = changed_r;
          out_index_nxt   = (drive_r && next_pos_r != '0) ? 4'(next_pos_r - 1'b1) : 4'd0;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration writes
  always_comb begin
    volume_nxt = volume_r;
    invert_nxt = invert_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pwmts_pkg::CFG_VOLUME: volume_nxt = cfg_ch.data;
        pwmts_pkg::CFG_INVERT: invert_nxt = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      loaded_r     <= '0;
      next_pos_r   <= '0;
      rem_ms_r     <= 16'd0;
      drive_r      <= 1'b0;
      cur_period_r <= 16'd0;
      cur_duty_r   <= 16'd0;
      changed_r    <= 1'b0;
      volume_r     <= pwmts_pkg::VOLUME_RESET;
      invert_r     <= pwmts_pkg::INVERT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      loaded_r     <= loaded_nxt;
      next_pos_r   <= next_pos_nxt;
      rem_ms_r     <= rem_ms_nxt;
      drive_r      <= drive_nxt;
      cur_period_r <= cur_period_nxt;
      cur_duty_r   <= cur_duty_nxt;
      changed_r    <= changed_nxt;
      volume_r     <= volume_nxt;
      invert_r     <= invert_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    mean_zero_r   <= mean_zero_nxt;
    lvl_r         <= lvl_nxt;
    lvl_scaled_r  <= lvl_scaled_nxt;
    dur_r         <= dur_nxt;
    period_r      <= period_nxt;
    duty_raw_r    <= duty_raw_nxt;
    out_drive_r   <= out_drive_nxt;
    out_period_r  <= out_period_nxt;
    out_duty_r    <= out_duty_nxt;
    out_changed_r <= out_changed_nxt;
    out_index_r   <= out_index_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_on      = out_drive_r;
  assign out_ch.period_us     = out_period_r;
  assign out_ch.duty_us       = out_duty_r;
  assign out_ch.tone_changed  = out_changed_r;
  assign out_ch.playing_index = out_index_r;

endmodule

`default_nettype wire

// File: rtl/core/pwmts_checker.sv
// Port-level checks of the PWM tone sequencer result channel, bound to the
// top level. Uses pwm_tone_sequencer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "pwm_tone_sequencer_macros.svh"

module pwmts_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire        drive_on,
  input wire [15:0] period_us,
  input wire [15:0] duty_us,
  input wire        tone_changed,
  input wire [3:0]  playing_index
);

  // Drive off reports a silent, zeroed tone
  `PWMTS_ASSERT_HOLDS(a_off_is_zero, clk, rst_n, out_valid && !drive_on, period_us == 16'd0 && duty_us == 16'd0 && playing_index == 4'd0)

  // A new tone always comes with the drive on and a real period
  `PWMTS_ASSERT_HOLDS(a_change_drives, clk, rst_n, out_valid && tone_changed, drive_on && period_us != 16'd0)

  // Duty never exceeds the period, inverted or not
  `PWMTS_ASSERT_HOLDS(a_duty_in_period, clk, rst_n, out_valid && drive_on, duty_us <= period_us && period_us <= 16'hfff0)

  // A stalled result holds
  `PWMTS_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(drive_on) && $stable(period_us) && $stable(duty_us) && $stable(tone_changed) && $stable(playing_index))

endmodule

bind pwm_tone_sequencer pwmts_checker u_pwmts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .drive_on      (out_ch.drive_on),
  .period_us     (out_ch.period_us),
  .duty_us       (out_ch.duty_us),
  .tone_changed  (out_ch.tone_changed),
  .playing_index (out_ch.playing_index)
);

`default_nettype wire

// File: test/pwmts_drive_checker.sv
// Scoreboard for the PWM tone sequencer: watches the item, result and register
// channels, predicts each result and compares. Uses pwmts_pkg and pwmts_if.
`timescale 1ns / 1ps

module pwmts_drive_checker #(
  parameter int MAX_TONES = 16
) (
  input  wire   clk,
  input  wire   rst_n,
  pwmts_in_if   in_ch,
  pwmts_out_if  out_ch,
  pwmts_cfg_if  cfg_ch,
  output int    mismatches,
  output int    results_checked
);
  import pwmts_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic        drive_on;
    logic [15:0] period_us;
    logic [15:0] duty_us;
    logic        tone_changed;
    logic [3:0]  playing_index;
  } drive_state_t;

  // Shadow copy of the block state
  tone_pitch_t  pitch_tab [MAX_TONES];
  tone_lt_t     lt_tab    [MAX_TONES];
  logic [4:0]   loaded;
  logic [4:0]   next_pos;
  logic [15:0]  remaining;
  logic         drive;
  logic [15:0]  cur_period;
  logic [15:0]  cur_duty;
  logic [9:0]   volume;
  logic         invert;

  drive_state_t predicted_drive_q [$];
  int           fail_count;
  int           match_count;

  // Load the tone at next_pos: period from the mean pitch, duty from the mean level
  function automatic void load_tone();
    tone_pitch_t p;
    tone_lt_t    lt;
    logic [16:0] freq_sum;
    logic [15:0] mean;
    logic [19:0] period;
    logic [10:0] lvl_sum;
    int unsigned scaled;
    int unsigned duty_wide;
    logic [15:0] duty;
    p        = pitch_tab[next_pos[3:0]];
    lt       = lt_tab[next_pos[3:0]];
    freq_sum = {1'b0, p.start_freq} + {1'b0, p.end_freq};
    mean     = freq_sum[16:1];
    if (mean == 16'd0) begin
      period = {4'b0, PERIOD_CAP};
    end else begin
      period = DIVIDEND / {4'b0, mean};
    end
    if (period > {4'b0, PERIOD_CAP}) begin
      period = {4'b0, PERIOD_CAP};
    end
    // mean of two 10-bit levels never exceeds 1023, so no cap needed
    lvl_sum   = {1'b0, lt.start_level} + {1'b0, lt.end_level};
    scaled    = (32'(lvl_sum[10:1]) * 32'(volume)) >> LEVEL_SHIFT;
    duty_wide = (32'(period) * scaled) >> LEVEL_SHIFT;
    duty      = duty_wide[15:0];
    if (invert) begin
      duty = period[15:0] - duty;
    end
    remaining  = lt.duration;
    cur_period = period[15:0];
    cur_duty   = duty;
    drive      = 1'b1;
    next_pos   = next_pos + 5'd1;
  endfunction

  // Step to the next tone of the list, or switch the drive off at its end
  function automatic logic step_playlist();
    if (loaded == 5'd0 || next_pos >= loaded) begin
      drive = 1'b0;
      return 1'b0;
    end
    load_tone();
    return 1'b1;
  endfunction

  function automatic drive_state_t predict_drive();
    drive_state_t res;
    logic         changed;
    logic [4:0]   cnt;
    changed = 1'b0;
    case (cmd_t'(in_ch.command))
      CMD_WRITE: begin
        pitch_tab[in_ch.tone_index] = '{end_freq: in_ch.end_frequency,
                                        start_freq: in_ch.start_frequency};
        lt_tab[in_ch.tone_index]    = '{duration: in_ch.duration_ms,
                                        end_level: in_ch.end_level,
                                        start_level: in_ch.start_level};
      end
      CMD_START: begin
        cnt       = in_ch.tone_count;
        loaded    = (cnt > 5'(MAX_TONES)) ? 5'(MAX_TONES) : cnt;
        next_pos  = 5'd0;
        remaining = 16'd0;
        changed   = step_playlist();
      end
      CMD_TICK: begin
        if (loaded == 5'd0) begin
          drive = 1'b0;
        end else begin
          if (remaining > 16'd0) remaining = remaining - 16'd1;
          if (remaining == 16'd0) changed = step_playlist();
        end
      end
      default: ;
    endcase
    res.drive_on      = drive;
    res.period_us     = drive ? cur_period : 16'd0;
    res.duty_us       = drive ? cur_duty : 16'd0;
    res.tone_changed  = changed;
    res.playing_index = (drive && next_pos > 5'd0) ? 4'(next_pos - 5'd1) : 4'd0;
    return res;
  endfunction

  // Monitor all three channels on the rising edge
  always @(posedge clk) begin
    drive_state_t got;
    drive_state_t want;
    if (!rst_n) begin
      loaded      = 5'd0;
      next_pos    = 5'd0;
      remaining   = 16'd0;
      drive       = 1'b0;
      cur_period  = 16'd0;
      cur_duty    = 16'd0;
      volume      = VOLUME_RESET;
      invert      = INVERT_RESET;
      fail_count  = 0;
      match_count = 0;
      predicted_drive_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_VOLUME) volume = cfg_ch.data;
        else if (cfg_ch.index == CFG_INVERT) invert = cfg_ch.data[0];
      end
      // compare before pushing: a result never belongs to the item taken this edge
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.drive_on, out_ch.period_us, out_ch.duty_us,
                out_ch.tone_changed, out_ch.playing_index};
        if (predicted_drive_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result transaction with nothing expected: on=%0d period=%0d duty=%0d chg=%0d idx=%0d",
                     $time, got.drive_on, got.period_us, got.duty_us,
                     got.tone_changed, got.playing_index);
        end else begin
          want = predicted_drive_q.pop_front();
          match_count++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: drive mismatch: exp on=%0d period=%0d duty=%0d chg=%0d idx=%0d, got on=%0d period=%0d duty=%0d chg=%0d idx=%0d",
                       $time, want.drive_on, want.period_us, want.duty_us,
                       want.tone_changed, want.playing_index, got.drive_on,
                       got.period_us, got.duty_us, got.tone_changed, got.playing_index);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_drive_q.push_back(predict_drive());
      end
    end
    mismatches      <= fail_count;
    results_checked <= match_count;
  end

endmodule

// File: test/pwm_tone_sequencer_tb.sv
// Top of the PWM tone sequencer testbench: clock, reset, stimulus and verdict.
// Depends on pwmts_pkg, pwmts_if, pwm_tone_sequencer and pwmts_drive_checker.
`timescale 1ns / 1ps

module pwm_tone_sequencer_tb;
  import pwmts_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 4;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 500;
  localparam int NUM_PHASES   = 5;
  localparam int PHASE_ITEMS  = 135;
  localparam int TONE_SLOTS   = 16;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   results_checked;
  int   items_sent = 0;
  bit   steady = 1'b0;

  pwmts_in_if  in_if ();
  pwmts_out_if out_if ();
  pwmts_cfg_if cfg_if ();

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  pwm_tone_sequencer #(.MAX_TONES(TONE_SLOTS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  pwmts_drive_checker #(.MAX_TONES(TONE_SLOTS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_if),
    .out_ch          (out_if),
    .cfg_ch          (cfg_if),
    .mismatches      (mismatches),
    .results_checked (results_checked)
  );

  // Idle gaps: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Pitches biased toward zero mean, capped periods and the uncapped range
  function automatic logic [15:0] rand_freq();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 3));
      1:       return 16'($urandom_range(4, 100));
      2:       return 16'($urandom_range(16, 5000));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(0, 4));
    if (r < 95) return 16'($urandom_range(5, 30));
    return 16'($urandom());
  endfunction

  // One input transaction, after a random gap
  task automatic send_item(input cmd_t cmd, input logic [3:0] idx,
                           input logic [15:0] f0, input logic [15:0] f1,
                           input logic [9:0] l0, input logic [9:0] l1,
                           input logic [15:0] dur, input logic [4:0] cnt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.command         <= cmd;
    in_if.tone_index      <= idx;
    in_if.start_frequency <= f0;
    in_if.end_frequency   <= f1;
    in_if.start_level     <= l0;
    in_if.end_level       <= l1;
    in_if.duration_ms     <= dur;
    in_if.tone_count      <= cnt;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic write_tone(input logic [3:0] idx, input logic [15:0] f0,
                            input logic [15:0] f1, input logic [9:0] l0,
                            input logic [9:0] l1, input logic [15:0] dur);
    send_item(CMD_WRITE, idx, f0, f1, l0, l1, dur, 5'($urandom()));
  endtask

  task automatic start_song(input logic [4:0] cnt);
    send_item(CMD_START, 4'($urandom()), 16'($urandom()), 16'($urandom()),
              10'($urandom()), 10'($urandom()), 16'($urandom()), cnt);
  endtask

  task automatic tick();
    send_item(CMD_TICK, 4'($urandom()), 16'($urandom()), 16'($urandom()),
              10'($urandom()), 10'($urandom()), 16'($urandom()), 5'($urandom()));
  endtask

  task automatic idle_item();
    send_item(CMD_NONE, 4'($urandom()), 16'($urandom()), 16'($urandom()),
              10'($urandom()), 10'($urandom()), 16'($urandom()), 5'($urandom()));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (results_checked < items_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_config(input logic [9:0] vol, input logic inv);
    write_reg(CFG_VOLUME, vol);
    write_reg(CFG_INVERT, CFG_DATA_W'(inv));
    cfg_if.valid <= 1'b0;
  endtask

  // Well-formed song: load a few tones, start, then run ticks through them
  task automatic play_song();
    int k;
    int base;
    int r;
    logic [4:0] cnt;
    k    = $urandom_range(1, 6);
    base = $urandom_range(0, TONE_SLOTS - k);
    for (int i = 0; i < k; i++) begin
      write_tone(4'(base + i), rand_freq(), rand_freq(), 10'($urandom()),
                 10'($urandom()), rand_duration());
    end
    r = $urandom_range(0, 99);
    if (r < 70) cnt = 5'(base + k);
    else if (r < 90) cnt = 5'($urandom_range(0, TONE_SLOTS));
    else cnt = 5'($urandom_range(TONE_SLOTS + 1, 31));
    start_song(cnt);
    repeat ($urandom_range(2, 24)) tick();
  endtask

  task automatic play_phase(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 80) begin
        play_song();
      end else begin
        send_item(cmd_t'(2'($urandom_range(0, 3))), 4'($urandom()), 16'($urandom()),
                  16'($urandom()), 10'($urandom()), 10'($urandom()),
                  16'($urandom()), 5'($urandom()));
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off while items keep coming
  initial begin
    int  stall;
    bit  held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("pwm_tone_sequencer_tb: errors");
    $finish;
  end

  // Main stimulus
  initial begin
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.command         <= CMD_NONE;
    in_if.tone_index      <= '0;
    in_if.start_frequency <= '0;
    in_if.end_frequency   <= '0;
    in_if.start_level     <= '0;
    in_if.end_level       <= '0;
    in_if.duration_ms     <= '0;
    in_if.tone_count      <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= '0;
    cfg_if.data           <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(VOLUME_RESET, INVERT_RESET);

    // Directed: idle ticks, empty start, unused command, edge-case tones
    tick();
    start_song(5'd0);
    idle_item();
    write_tone(4'd0, 16'd0, 16'd0, 10'd1023, 10'd1023, 16'd0);          // zero mean pitch
    write_tone(4'd1, 16'hffff, 16'hffff, 10'd0, 10'd0, 16'd1);          // top pitch, silent
    write_tone(4'd2, 16'd1, 16'd1, 10'd1023, 10'd0, 16'd2);             // huge period, capped
    write_tone(4'd3, 16'd16, 16'd16, 10'd512, 10'd511, 16'd3);
    write_tone(4'd15, 16'hffff, 16'd0, 10'd1, 10'd1023, 16'hffff);
    start_song(5'd4);
    repeat (4) tick();
    idle_item();
    repeat (4) tick();                                                  // list runs out
    // fill the rest of the table, then a count above the table size
    for (int i = 4; i < TONE_SLOTS - 1; i++) begin
      write_tone(4'(i), rand_freq(), rand_freq(), 10'($urandom()), 10'($urandom()),
                 16'($urandom_range(0, 2)));
    end
    start_song(5'd31);
    repeat (32) tick();

    // Random phases, each behind a drained pipeline and a new register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       set_config(10'd0, 1'b0);
        1:       set_config(10'd1023, 1'b0);
        2:       set_config(10'($urandom()), 1'b1);
        3:       set_config(10'd1, 1'b1);
        default: set_config(10'($urandom()), 1'($urandom()));
      endcase
      steady = (ph == 3);
      play_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("pwm_tone_sequencer_tb: clean");
    end else begin
      $display("pwm_tone_sequencer_tb: errors");
    end
    $finish;
  end

endmodule
